@@ hdl/ptwa_pkg.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: shared package
// Widths, action and status codes, reset constants and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwa_pkg;

  localparam int TABLE_SIZE_DEF = 8;

  localparam int ACT_W    = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int MAC_W    = 48;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 4;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd5000;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_FRAME    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWEEP    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIRST    = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK_EXIST = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK_NEW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/ptwa_ram.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ptwa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: controller
// Sequences one item through scan, commit and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_ctrl import ptwa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.start  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.scan   = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_COMMIT);
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_HOLD);

endmodule

`default_nettype wire

@@ hdl/ptwa_datapath.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: datapath
// Slot RAM, per-slot valid bits, the scan compare stage and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_datapath import ptwa_pkg::*; #(
  parameter int TableSize = TABLE_SIZE_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [TIME_W-1:0]   cfg_wdata_i,
  input  wire logic [ACT_W-1:0]    action_i,
  input  wire logic [MAC_W-1:0]    peer_mac_i,
  input  wire logic [ID_W-1:0]     node_id_i,
  input  wire logic                length_ok_i,
  input  wire logic [TIME_W-1:0]   now_ms_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [SLOT_W-1:0]   slot_o,
  output logic      [MAC_W-1:0]    mac_out_o,
  output logic      [ID_W-1:0]     id_out_o,
  output logic                     connected_o,
  output logic      [CNT_W-1:0]    removed_count_o,
  output logic      [CNT_W-1:0]    peer_count_o
);

  localparam int AW = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int CW = $clog2(TableSize + 1);
  localparam int EW = MAC_W + ID_W + TIME_W;

  // Item registers.
  logic [ACT_W-1:0]  act_q;
  logic [MAC_W-1:0]  mac_q;
  logic [ID_W-1:0]   id_q;
  logic              len_ok_q;
  logic [TIME_W-1:0] now_q;

  logic [TIME_W-1:0]    timeout_q;
  logic [TableSize-1:0] valid_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        scan_cnt_q;
  logic                 cmp_en_q;
  logic [AW-1:0]        cmp_idx_q;
  logic [CW-1:0]        removed_q;

  logic              hit_found_q;
  logic [AW-1:0]     hit_idx_q;
  logic [MAC_W-1:0]  hit_mac_q;
  logic [ID_W-1:0]   hit_id_q;
  logic [TIME_W-1:0] hit_last_q;
  logic              hit_conn_q;
  logic              free_found_q;
  logic [AW-1:0]     free_idx_q;

  // Slot RAM.
  logic          rd_en;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  assign rd_en = cmd_i.scan && (scan_cnt_q != CW'(TableSize));
  assign sts_o.scan_done = (scan_cnt_q == CW'(TableSize));

  ptwa_ram #(
    .Width (EW),
    .Depth (TableSize)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (scan_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Compare stage: one slot per cycle, working on the slot read in the cycle before.
  logic [MAC_W-1:0]  rd_mac;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_last;
  logic [TIME_W-1:0] age;
  logic              cur_valid;
  logic              heard;
  logic              hit_cond;
  logic              stale;
  logic              take_hit;
  logic              take_free;

  assign rd_mac    = ram_rdata[EW-1 -: MAC_W];
  assign rd_id     = ram_rdata[TIME_W +: ID_W];
  assign rd_last   = ram_rdata[TIME_W-1:0];
  assign cur_valid = valid_q[cmp_idx_q];
  assign heard     = (rd_last != '0);
  assign age       = now_q - rd_last;

  always_comb begin
    case (act_q) inside
      ACT_FRAME, ACT_REGISTER: hit_cond = cur_valid && (rd_mac == mac_q);
      ACT_LOOKUP, ACT_QUERY:   hit_cond = cur_valid && (rd_id == id_q);
      ACT_FIRST:               hit_cond = cur_valid && heard;
      default:                 hit_cond = 1'b0;
    endcase
  end

  assign stale     = cmp_en_q && (act_q == ACT_SWEEP) && cur_valid &&
                     (!heard || (age > timeout_q));
  assign take_hit  = cmp_en_q && hit_cond && !hit_found_q;
  assign take_free = cmp_en_q && !cur_valid && !free_found_q;

  // Commit decision once the scan has seen every slot.
  logic                id_ok;
  logic                learn;
  logic                do_write;
  logic                res_hit;
  logic [STATUS_W-1:0] res_status;
  logic [AW-1:0]       res_idx;
  logic [MAC_W-1:0]    res_mac;
  logic [ID_W-1:0]     res_id;
  logic                res_conn;
  logic [CW-1:0]       count_next;

  assign id_ok = (id_q < ID_W'(TableSize));

  always_comb begin
    learn      = 1'b0;
    do_write   = 1'b0;
    res_hit    = 1'b0;
    res_status = ST_NOT_FOUND;
    res_mac    = hit_mac_q;
    res_id     = hit_id_q;
    ram_wdata  = {hit_mac_q, hit_id_q, now_q};
    case (act_q) inside
      ACT_FRAME: begin
        if (!len_ok_q) begin
          res_status = ST_BAD_LEN;
        end else if (hit_found_q) begin
          res_status = ST_OK_EXIST;
          res_hit    = 1'b1;
          do_write   = 1'b1;
        end else if (!id_ok) begin
          res_status = ST_BAD_ID;
        end else if (free_found_q) begin
          res_status = ST_OK_NEW;
          res_hit    = 1'b1;
          learn      = 1'b1;
          do_write   = 1'b1;
          res_mac    = mac_q;
          res_id     = id_q;
          ram_wdata  = {mac_q, id_q, now_q};
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_REGISTER: begin
        if (!id_ok) begin
          res_status = ST_BAD_ID;
        end else if (hit_found_q) begin
          res_status = ST_OK_EXIST;
          res_hit    = 1'b1;
          do_write   = 1'b1;
          res_id     = id_q;
          ram_wdata  = {hit_mac_q, id_q, hit_last_q};
        end else if (free_found_q) begin
          // A registered peer starts out as never heard.
          res_status = ST_OK_NEW;
          res_hit    = 1'b1;
          learn      = 1'b1;
          do_write   = 1'b1;
          res_mac    = mac_q;
          res_id     = id_q;
          ram_wdata  = {mac_q, id_q, {TIME_W{1'b0}}};
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_LOOKUP, ACT_QUERY, ACT_FIRST: begin
        res_hit    = hit_found_q;
        res_status = hit_found_q ? ST_OK_EXIST : ST_NOT_FOUND;
      end
      ACT_SWEEP: begin
        res_status = ST_OK_EXIST;
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  assign res_idx    = learn ? free_idx_q : hit_idx_q;
  assign res_conn   = (act_q == ACT_QUERY) && hit_found_q && hit_conn_q;
  assign ram_we     = cmd_i.commit && do_write;
  assign ram_waddr  = res_idx;
  assign count_next = count_q + CW'(learn);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TIMEOUT_RST;
      valid_q      <= '0;
      count_q      <= '0;
      scan_cnt_q   <= '0;
      cmp_en_q     <= 1'b0;
      removed_q    <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      cmp_en_q <= rd_en;
      if (cmd_i.start) begin
        scan_cnt_q   <= '0;
        removed_q    <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end
      if (rd_en) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (take_hit) begin
        hit_found_q <= 1'b1;
      end
      if (take_free) begin
        free_found_q <= 1'b1;
      end
      // Aged-out slots only lose their valid bit; the RAM entry is dead.
      if (stale) begin
        valid_q[cmp_idx_q] <= 1'b0;
        count_q            <= count_q - 1'b1;
        removed_q          <= removed_q + 1'b1;
      end
      if (cmd_i.commit && learn) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q             <= count_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q    <= action_i;
      mac_q    <= peer_mac_i;
      id_q     <= node_id_i;
      len_ok_q <= length_ok_i;
      now_q    <= now_ms_i;
    end
    if (rd_en) begin
      cmp_idx_q <= scan_cnt_q[AW-1:0];
    end
    if (take_hit) begin
      hit_idx_q  <= cmp_idx_q;
      hit_mac_q  <= rd_mac;
      hit_id_q   <= rd_id;
      hit_last_q <= rd_last;
      hit_conn_q <= heard && (age < timeout_q);
    end
    if (take_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.commit) begin
      status_o        <= res_status;
      slot_o          <= res_hit ? SLOT_W'(res_idx) : '0;
      mac_out_o       <= res_hit ? res_mac : '0;
      id_out_o        <= res_hit ? res_id : '0;
      connected_o     <= res_conn;
      removed_count_o <= CNT_W'(removed_q);
      peer_count_o    <= CNT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

@@ hdl/peer_table_with_aging_unit.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: top level
// A peer table of TABLE_SIZE slots keyed by 48-bit MAC or by node id; each
// item is a frame, register, lookup, connection query, age sweep or
// first-active request and yields exactly one result item. An accepted item
// is scanned one slot per cycle through the single read port of the slot
// RAM. The scan then lets the last read data reach the compare stage, and
// the commit state registers the result. The result is offered on
// out_valid_o and can be taken in the cycle it is first offered. The block
// takes the next item in the cycle after its result has been taken. The
// aging timeout is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_table_with_aging_unit import ptwa_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TIME_W-1:0]   cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ACT_W-1:0]    action_i,
  input  wire logic [MAC_W-1:0]    peer_mac_i,
  input  wire logic [ID_W-1:0]     node_id_i,
  input  wire logic                length_ok_i,
  input  wire logic [TIME_W-1:0]   now_ms_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [SLOT_W-1:0]   slot_o,
  output logic      [MAC_W-1:0]    mac_out_o,
  output logic      [ID_W-1:0]     id_out_o,
  output logic                     connected_o,
  output logic      [CNT_W-1:0]    removed_count_o,
  output logic      [CNT_W-1:0]    peer_count_o
);

  cmd_t cmd;
  sts_t sts;

  ptwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptwa_datapath #(
    .TableSize (TABLE_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .action_i        (action_i),
    .peer_mac_i      (peer_mac_i),
    .node_id_i       (node_id_i),
    .length_ok_i     (length_ok_i),
    .now_ms_i        (now_ms_i),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .mac_out_o       (mac_out_o),
    .id_out_o        (id_out_o),
    .connected_o     (connected_o),
    .removed_count_o (removed_count_o),
    .peer_count_o    (peer_count_o)
  );

endmodule

`default_nettype wire

@@ hdl/ptwa_checker.sv @@
// ----------------------------------------------------------------------------
// Peer table with aging: port checker
// Checks on what the top-level ports show over time, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwa_checker import ptwa_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [SLOT_W-1:0]   slot_o,
  input wire logic [MAC_W-1:0]    mac_out_o,
  input wire logic [ID_W-1:0]     id_out_o,
  input wire logic                connected_o,
  input wire logic [CNT_W-1:0]    removed_count_o
);

  // One item at a time: no new item while a result is on offer.
  a_stall_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item input open while a result is pending");

  // A result never shows up in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared without a table scan");

  // A miss carries no slot contents.
  a_miss_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOT_FOUND) |->
      (slot_o == '0 && mac_out_o == '0 && id_out_o == '0 && !connected_o))
    else $error("not-found result carries slot data");

  // Only a successful query reports a connected peer; only a sweep removes.
  a_flags_need_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (connected_o || removed_count_o != '0)) |->
      (status_o == ST_OK_EXIST))
    else $error("connected or removed count with a failing status");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(mac_out_o) && $stable(slot_o)))
    else $error("stalled result changed");

endmodule

bind peer_table_with_aging_unit ptwa_checker u_ptwa_checker (.*);

`default_nettype wire
